// ===== rtl/core/rbei_pkg.sv =====
// Package for the rigid body Euler integrator: payload structs, register
// indexes, default constants and the 32-bit saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package rbei_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [1:0] REG_GRAVITY_X = 2'd0;
  localparam logic [1:0] REG_GRAVITY_Y = 2'd1;
  localparam logic [1:0] REG_TIME_STEP = 2'd2;

  localparam logic signed [31:0] GRAVITY_X_RST = 32'sd0;
  localparam logic signed [31:0] GRAVITY_Y_RST = -32'sd642252;
  localparam logic [19:0]        TIME_STEP_RST = 20'd1092;

  localparam logic [1:0] KIND_KINEMATIC = 2'd2;
  localparam logic [1:0] KIND_DYNAMIC   = 2'd3;

  typedef struct packed {
    logic               body_valid;
    logic [1:0]         body_kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic [30:0]        mass;
  } body_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               saturated;
    logic               mass_error;
  } body_out_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } sat_t;

  function automatic sat_t sat32(logic signed [63:0] v);
    sat_t r;
    if (v > 64'sd2147483647) begin
      r.val = 32'sh7fffffff;
      r.sat = 1'b1;
    end else if (v < -64'sd2147483648) begin
      r.val = 32'sh80000000;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/rigid_body_euler_integrator.sv =====
// Top level of the 2-D semi-implicit Euler integrator: configuration
// registers and the full integration pipeline. Depends on rbei_pkg.
// An accepted input passes through registers a and b, the divider stages, registers c to f and the output register.
// Throughput: one transaction per cycle while no result is stalled; the 32-stage restoring divider for
// force over mass sets the depth, one quotient bit per stage.
// The whole pipeline advances together and holds while a result is stalled.
// Reset clears all stage valid bits and loads the register defaults.
`timescale 1ns / 1ps

module rigid_body_euler_integrator
  import rbei_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  body_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output body_out_t   out_data_o
);

  localparam int DivSteps = 32;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] nq;
    logic        neg;
    logic        ovf;
  } lane_t;

  typedef struct packed {
    logic               vld;
    logic               dyn;
    logic               mov;
    logic               merr;
    logic               sat;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic [30:0]        mass;
    lane_t              lx;
    lane_t              ly;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [52:0] mx;
    logic signed [52:0] my;
  } pipe_t;

  logic signed [31:0] grav_x_q, grav_y_q;
  logic [19:0]        tstep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_x_q <= GRAVITY_X_RST;
      grav_y_q <= GRAVITY_Y_RST;
      tstep_q  <= TIME_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRAVITY_X: grav_x_q <= cfg_data_i;
        REG_GRAVITY_Y: grav_y_q <= cfg_data_i;
        REG_TIME_STEP: tstep_q  <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  function automatic lane_t lane_init(logic signed [31:0] f, logic [30:0] m);
    lane_t       l;
    logic [31:0] mag;
    logic [63:0] dvd;
    l.neg = f[31];
    mag   = f[31] ? 32'(-f) : 32'(f);
    dvd   = {32'b0, mag} << FRAC_BITS;
    l.ovf = dvd >= {1'b0, m, 32'b0};
    l.rem = dvd[63:32];
    l.nq  = dvd[31:0];
    return l;
  endfunction

  function automatic lane_t div_step(lane_t l, logic [30:0] m);
    lane_t       o;
    logic [32:0] r;
    o = l;
    r = {l.rem, l.nq[31]};
    if (r >= {2'b0, m}) begin
      o.rem = 32'(r - {2'b0, m});
      o.nq  = {l.nq[30:0], 1'b1};
    end else begin
      o.rem = r[31:0];
      o.nq  = {l.nq[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sat_t quot_sat(lane_t l);
    sat_t r;
    if (l.ovf || (!l.neg && l.nq[31])) begin
      r.val = l.neg ? 32'sh80000000 : 32'sh7fffffff;
      r.sat = 1'b1;
    end else if (l.neg && (l.nq > 32'h80000000)) begin
      r.val = 32'sh80000000;
      r.sat = 1'b1;
    end else begin
      r.val = l.neg ? 32'(-l.nq) : l.nq;
      r.sat = 1'b0;
    end
    return r;
  endfunction

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  pipe_t a_d, a_q, b_d, b_q, c_d, c_q, d_d, d_q, e_d, e_q, f_d, f_q;
  body_out_t out_d, out_q;
  logic      out_vld_q;

  logic signed [20:0] ts_s;
  assign ts_s = $signed({1'b0, tstep_q});

  always_comb begin
    a_d      = '0;
    a_d.vld  = in_valid_i;
    a_d.dyn  = in_data_i.body_valid && (in_data_i.body_kind == KIND_DYNAMIC)
               && (in_data_i.mass != '0);
    a_d.merr = in_data_i.body_valid && (in_data_i.body_kind == KIND_DYNAMIC)
               && (in_data_i.mass == '0);
    a_d.mov  = in_data_i.body_valid && in_data_i.body_kind[1];
    a_d.px   = in_data_i.pos_x;
    a_d.py   = in_data_i.pos_y;
    a_d.vx   = in_data_i.vel_x;
    a_d.vy   = in_data_i.vel_y;
    a_d.fx   = in_data_i.force_x;
    a_d.fy   = in_data_i.force_y;
    a_d.mass = in_data_i.mass;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else if (en) begin
      a_q <= a_d;
    end
  end

  always_comb begin
    sat_t sx, sy;
    b_d    = a_q;
    sx     = sat32(64'(a_q.fx) + 64'(grav_x_q));
    sy     = sat32(64'(a_q.fy) + 64'(grav_y_q));
    b_d.fx = sx.val;
    b_d.fy = sy.val;
    b_d.sat = a_q.dyn && (sx.sat || sy.sat);
    b_d.lx = lane_init(sx.val, a_q.mass);
    b_d.ly = lane_init(sy.val, a_q.mass);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (en) begin
      b_q <= b_d;
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    pipe_t src, nxt, stage_q;
    if (k == 0) begin : g_first
      assign src = b_q;
    end else begin : g_rest
      assign src = g_div[k-1].stage_q;
    end
    always_comb begin
      nxt    = src;
      nxt.lx = div_step(src.lx, src.mass);
      nxt.ly = div_step(src.ly, src.mass);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stage_q <= '0;
      end else if (en) begin
        stage_q <= nxt;
      end
    end
  end

  always_comb begin
    sat_t qx, qy;
    c_d    = g_div[DivSteps-1].stage_q;
    qx     = quot_sat(c_d.lx);
    qy     = quot_sat(c_d.ly);
    c_d.ax = qx.val;
    c_d.ay = qy.val;
    c_d.sat = c_d.sat || (c_d.dyn && (qx.sat || qy.sat));
  end

  always_comb begin
    d_d    = c_q;
    d_d.mx = 53'(c_q.ax) * 53'(ts_s);
    d_d.my = 53'(c_q.ay) * 53'(ts_s);
  end

  always_comb begin
    sat_t vx, vy;
    e_d = d_q;
    vx  = sat32(64'(d_q.vx) + (64'(d_q.mx) >>> FRAC_BITS));
    vy  = sat32(64'(d_q.vy) + (64'(d_q.my) >>> FRAC_BITS));
    if (d_q.dyn) begin
      e_d.vx  = vx.val;
      e_d.vy  = vy.val;
      e_d.sat = d_q.sat || vx.sat || vy.sat;
    end
  end

  always_comb begin
    f_d    = e_q;
    f_d.mx = 53'(e_q.vx) * 53'(ts_s);
    f_d.my = 53'(e_q.vy) * 53'(ts_s);
  end

  always_comb begin
    sat_t px, py;
    px               = sat32(64'(f_q.px) + (64'(f_q.mx) >>> FRAC_BITS));
    py               = sat32(64'(f_q.py) + (64'(f_q.my) >>> FRAC_BITS));
    out_d.new_pos_x  = f_q.mov ? px.val : f_q.px;
    out_d.new_pos_y  = f_q.mov ? py.val : f_q.py;
    out_d.new_vel_x  = f_q.vx;
    out_d.new_vel_y  = f_q.vy;
    out_d.saturated  = f_q.sat || (f_q.mov && (px.sat || py.sat));
    out_d.mass_error = f_q.merr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q       <= '0;
      d_q       <= '0;
      e_q       <= '0;
      f_q       <= '0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      c_q       <= c_d;
      d_q       <= d_d;
      e_q       <= e_d;
      f_q       <= f_d;
      out_q     <= out_d;
      out_vld_q <= f_q.vld;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
